// ===== rtl/core/sps_pkg.sv =====
`default_nettype none
package sps_pkg;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ORDER    = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
    logic [1:0]  status;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/sps_front.sv =====
`default_nettype none
module sps_front #(
  parameter int VALUE_BITS = 20,
  parameter int SEG_MAX    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] range_low,
  input  wire logic [VALUE_BITS-1:0] range_high,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output sps_pkg::job_t              job
);
  import sps_pkg::*;

  job_t                job_in;
  logic [VALUE_BITS:0] span;

  // classify range and check its length
  always_comb begin
    span          = {1'b0, range_high} - {1'b0, range_low};
    job_in        = '0;
    job_in.low    = 32'(range_low);
    job_in.high   = 32'(range_high);
    job_in.status = STATUS_OK;
    if (range_high < range_low) begin
      job_in.status = STATUS_ORDER;
    end else if (span >= (VALUE_BITS+1)'(SEG_MAX)) begin
      job_in.status = STATUS_TOO_LONG;
    end
  end

  // two-entry queue toward the back end
  job_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign in_ready  = (cnt != 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q[wp] <= job_in;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wp <= ~wp;
      end
      if (job_valid && job_ready) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((job_valid && job_ready) ? 1 : 0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !job_ready) |=> cnt == 2'd2)
    else $error("queue lost an entry");
  assert property (@(posedge clk) disable iff (rst) job_valid |-> job.status != 2'd3)
    else $error("bad status code queued");
endmodule
`default_nettype wire

// ===== rtl/core/sps_back.sv =====
`default_nettype none
module sps_back #(
  parameter int VALUE_BITS = 20,
  parameter int SEG_MAX    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  wire sps_pkg::job_t         job,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      number,
  output logic                       is_prime,
  output logic [1:0]                 status,
  output logic                       last
);
  import sps_pkg::*;

  localparam int RB        = (VALUE_BITS + 1) / 2;
  localparam int BASE_DEPTH = 1 << RB;
  localparam int SB        = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
  localparam int CB        = SB + 1;
  localparam int DB        = $clog2(VALUE_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQRT  = 4'd1;
  localparam logic [3:0] S_BINIT = 4'd2;
  localparam logic [3:0] S_BOUT  = 4'd3;
  localparam logic [3:0] S_BMARK = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCHK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_SMARK = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_ERR   = 4'd12;
  localparam logic [3:0] S_BCHK  = 4'd13;

  logic [3:0]            state;
  logic [VALUE_BITS-1:0] low, high;
  logic [1:0]            err;
  logic [RB:0]           limit;     // floor(sqrt(high))
  logic [RB:0]           bit_pos;   // one-hot-ish trial bit for sqrt
  logic [RB:0]           i;         // base sieve / prime walk index
  logic [2*RB+1:0]       j;         // marking pointer
  logic [VALUE_BITS:0]   rem;       // remainder of low / p
  logic [DB-1:0]         dcnt;
  logic [DB-1:0]         bit_idx;
  logic [CB-1:0]         k;
  logic [CB-1:0]         len;
  logic                  base_mem [BASE_DEPTH];
  logic                  seg_mem  [SEG_MAX];
  logic                  base_rd;
  logic                  seg_rd_out;
  logic [2*RB+1:0]       trial_sq;
  logic [RB:0]           trial;
  logic [2*RB+1:0]       i_sq;
  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   rem_nx;
  logic [VALUE_BITS+1:0] jm;

  // sqrt trial and products (narrow multipliers, one per state path)
  always_comb begin
    trial    = limit | bit_pos;
    trial_sq = (2*RB+2)'(trial) * (2*RB+2)'(trial);
    i_sq     = (2*RB+2)'(i) * (2*RB+2)'(i);
    bit_idx  = DB'(VALUE_BITS - 1) - dcnt;
    rem_sh   = {rem[VALUE_BITS-1:0], low[bit_idx]};
    rem_nx   = (rem_sh >= (VALUE_BITS+1)'(i)) ? rem_sh - (VALUE_BITS+1)'(i) : rem_sh;
    jm       = (VALUE_BITS+2)'(j) - (VALUE_BITS+2)'(low);
  end

  assign job_ready = (state == S_IDLE);
  assign is_prime  = seg_rd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            low   <= job.low[VALUE_BITS-1:0];
            high  <= job.high[VALUE_BITS-1:0];
            err   <= job.status;
            len   <= CB'(job.high[VALUE_BITS-1:0] - job.low[VALUE_BITS-1:0]) + CB'(1);
            limit <= '0;
            bit_pos <= (RB+1)'(1) << (RB - 1);
            state <= (job.status != STATUS_OK) ? S_ERR : S_SQRT;
          end
        end
        // bitwise integer square root, one bit per cycle
        S_SQRT: begin
          if (trial_sq <= (2*RB+2)'(high)) limit <= trial;
          bit_pos <= bit_pos >> 1;
          if (bit_pos == (RB+1)'(1)) begin
            i     <= '0;
            state <= S_BINIT;
          end
        end
        // base flags 0..limit set, 0 and 1 cleared
        S_BINIT: begin
          base_mem[i[RB-1:0]] <= (i >= (RB+1)'(2));
          if (i == limit || i == (RB+1)'(BASE_DEPTH - 1)) begin
            i     <= (RB+1)'(2);
            state <= S_BOUT;
          end else begin
            i <= i + 1'b1;
          end
        end
        // outer base loop: read flag of i
        S_BOUT: begin
          if (i_sq > (2*RB+2)'(limit)) begin
            k     <= '0;
            state <= S_SINIT;
          end else begin
            base_rd <= base_mem[i[RB-1:0]];
            j       <= i_sq;
            state   <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (base_rd) state <= S_BMARK;
          else begin
            i     <= i + 1'b1;
            state <= S_BOUT;
          end
        end
        S_BMARK: begin
          if (j > (2*RB+2)'(limit)) begin
            i     <= i + 1'b1;
            state <= S_BOUT;
          end else begin
            base_mem[j[RB-1:0]] <= 1'b0;
            j <= j + (2*RB+2)'(i);
          end
        end
        // segment flags set, 0 and 1 cleared
        S_SINIT: begin
          seg_mem[k[SB-1:0]] <= !((VALUE_BITS+1)'(low) + (VALUE_BITS+1)'(k) <= (VALUE_BITS+1)'(1));
          if (k + 1'b1 == len) begin
            i     <= (RB+1)'(2);
            state <= S_PRD;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_PRD: begin
          if (i > limit) begin
            k     <= '0;
            state <= S_ERD;
          end else begin
            base_rd <= base_mem[i[RB-1:0]];
            state   <= S_PCHK;
          end
        end
        // bit-serial remainder of low by p
        S_PCHK: begin
          if (!base_rd) begin
            i     <= i + 1'b1;
            state <= S_PRD;
          end else begin
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        // first multiple at or above low; p*p floor is applied in S_SMARK
        S_DIV: begin
          rem  <= rem_nx;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DB'(VALUE_BITS - 1)) begin
            state <= S_SMARK;
            if (rem_nx == '0)
              j <= (2*RB+2)'(low);
            else
              j <= (2*RB+2)'(low) + (2*RB+2)'(i) - (2*RB+2)'(rem_nx);
          end
        end
        S_SMARK: begin
          if (j < i_sq) j <= i_sq;
          else if (j > (2*RB+2)'(high)) begin
            i     <= i + 1'b1;
            state <= S_PRD;
          end else begin
            seg_mem[jm[SB-1:0]] <= 1'b0;
            j <= j + (2*RB+2)'(i);
          end
        end
        // emit results through output register
        S_ERD: begin
          if (!out_valid || out_ready) begin
            seg_rd_out <= seg_mem[k[SB-1:0]];
            number     <= low + VALUE_BITS'(k);
            status     <= STATUS_OK;
            last       <= (k + 1'b1 == len);
            out_valid  <= 1'b1;
            if (k + 1'b1 == len) state <= S_EMIT;
            k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_ERR: begin
          if (!out_valid || out_ready) begin
            seg_rd_out <= 1'b0;
            number     <= '0;
            status     <= err;
            last       <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (out_valid && last) |-> status != 2'd3)
    else $error("bad status");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (last && !is_prime))
    else $error("error result malformed");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !out_valid)
    else $error("result pending while idle");
endmodule
`default_nettype wire

// ===== rtl/core/segmented_prime_sieve_unit.sv =====
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_ready   | range_low, range_high
// out     | out_valid / out_ready | number, is_prime, status, last
// front end classifies and queues up to two ranges; back end sieves one at a time
// per range: bitwise sqrt of high, base flag init up to limit, base sieve by marking,
// segment flag init, then per base prime a bit-serial remainder of low and segment
// marks, then one result per cycle while out_ready is high
// rst is synchronous and clears control state; memories are rewritten per range
// out stall holds the back end; input stalls only when the queue is full
module segmented_prime_sieve_unit #(
  parameter int VALUE_BITS = 20,
  parameter int SEG_MAX    = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] range_low,
  input  wire logic [VALUE_BITS-1:0] range_high,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      number,
  output logic                       is_prime,
  output logic [1:0]                 status,
  output logic                       last
);
  import sps_pkg::*;

  job_t job;
  logic job_valid, job_ready;

  sps_front #(.VALUE_BITS(VALUE_BITS), .SEG_MAX(SEG_MAX)) u_front (
    .clk, .rst, .in_valid, .in_ready, .range_low, .range_high,
    .job_valid, .job_ready, .job
  );

  sps_back #(.VALUE_BITS(VALUE_BITS), .SEG_MAX(SEG_MAX)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .number, .is_prime, .status, .last
  );
endmodule
`default_nettype wire
